// ----- hdl/olbt_pkg.sv -----
// Shared constants, codes and types for the ordered byte list table.
`timescale 1ns / 1ps
`default_nettype none
package olbt_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_APPEND  = 3'd0,
      MODE_DELETE  = 3'd1,
      MODE_COUNT   = 3'd2,
      MODE_REPLACE = 3'd3,
      MODE_CLEAR   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   // Broadcast from the controller to the whole row of cells.
   typedef struct packed {
      logic             shift;
      logic             load;
      logic [IDX_W-1:0] load_idx;
      logic [7:0]       data;
   } chain_ctrl_type;

   // What one cell sees of the broadcast.
   typedef struct packed {
      logic       shift;
      logic       load_en;
      logic [7:0] data;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ----- hdl/olbt_cell.sv -----
// One storage cell of the list row: holds a byte, loads it or takes its right neighbor's.
`timescale 1ns / 1ps
`default_nettype none
module olbt_cell (
   input  wire                    clock,
   input  olbt_pkg::cell_ctrl_type ctrl,
   input  wire  [7:0]             right_value,
   output logic [7:0]             value
);
   import olbt_pkg::*;

   logic [7:0] value_ff;
   logic [7:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load_en) begin
         value_in = ctrl.data;
      end else if (ctrl.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

// ----- hdl/olbt_ctrl.sv -----
// Sequencer for the list row: walks the entries, tracks the length and holds the result beat.
`timescale 1ns / 1ps
`default_nettype none
module olbt_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire  [2:0]               req_mode,
   input  wire  [7:0]               req_match_value,
   input  wire  [7:0]               req_replacement,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic [4:0]               rsp_matched_count,
   output logic                     rsp_success,
   output logic [4:0]               rsp_length_after,
   input  wire  [7:0]               head_value,
   output olbt_pkg::chain_ctrl_type chain
);
   import olbt_pkg::*;

   state_type        state_ff, state_in;
   logic [2:0]       mode_ff, mode_in;
   logic [7:0]       key_ff, key_in;
   logic [7:0]       repl_ff, repl_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic [CNT_W-1:0] hits_ff, hits_in;
   logic             ok_ff, ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [4:0]       rsp_matched_ff, rsp_matched_in;
   logic             rsp_success_ff, rsp_success_in;
   logic [4:0]       rsp_length_ff, rsp_length_in;

   logic             is_scan;
   logic             step_active;
   logic             head_match;
   logic             keep;
   logic [CNT_W-1:0] ins_pos;
   logic             out_free;

   assign is_scan = (mode_ff == MODE_DELETE) || (mode_ff == MODE_COUNT) ||
                    (mode_ff == MODE_REPLACE);
   assign step_active = is_scan && (step_ff < count_ff);
   assign head_match  = (head_value == key_ff);
   assign keep        = !((mode_ff == MODE_DELETE) && head_match);
   // Kept entries pile up just behind the entries not yet visited.
   assign ins_pos     = count_ff - CNT_W'(1) - step_ff + kept_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!step_active) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control and register updates.
   always_comb begin
      mode_in        = mode_ff;
      key_in         = key_ff;
      repl_in        = repl_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      kept_in        = kept_ff;
      hits_in        = hits_ff;
      ok_in          = ok_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_matched_in = rsp_matched_ff;
      rsp_success_in = rsp_success_ff;
      rsp_length_in  = rsp_length_ff;
      chain.shift    = 1'b0;
      chain.load     = 1'b0;
      chain.load_idx = '0;
      chain.data     = head_value;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode;
               key_in  = req_match_value;
               repl_in = req_replacement;
               step_in = '0;
               kept_in = '0;
               hits_in = '0;
               ok_in   = 1'b0;
            end
         end
         ST_SCAN: begin
            if (step_active) begin
               chain.shift    = 1'b1;
               chain.load     = keep;
               chain.load_idx = ins_pos[IDX_W-1:0];
               if ((mode_ff == MODE_REPLACE) && head_match) begin
                  chain.data = repl_ff;
               end
               step_in = step_ff + CNT_W'(1);
               if (keep) begin
                  kept_in = kept_ff + CNT_W'(1);
               end
               if (head_match) begin
                  hits_in = hits_ff + CNT_W'(1);
               end
            end else begin
               case (mode_ff)
                  MODE_APPEND: begin
                     if (count_ff < CNT_W'(DEPTH)) begin
                        chain.load     = 1'b1;
                        chain.load_idx = count_ff[IDX_W-1:0];
                        chain.data     = key_ff;
                        count_in       = count_ff + CNT_W'(1);
                        ok_in          = 1'b1;
                     end
                  end
                  MODE_DELETE: begin
                     count_in = kept_ff;
                     ok_in    = 1'b1;
                  end
                  MODE_COUNT:   ok_in = 1'b1;
                  MODE_REPLACE: ok_in = 1'b1;
                  MODE_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                  end
                  default: ok_in = 1'b0;
               endcase
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = 5'(hits_ff);
               rsp_success_in = ok_ff;
               rsp_length_in  = 5'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      key_ff         <= key_in;
      repl_ff        <= repl_in;
      step_ff        <= step_in;
      kept_ff        <= kept_in;
      hits_ff        <= hits_in;
      ok_ff          <= ok_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_success_ff <= rsp_success_in;
      rsp_length_ff  <= rsp_length_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched_count = rsp_matched_ff;
   assign rsp_success       = rsp_success_ff;
   assign rsp_length_after  = rsp_length_ff;

endmodule
`default_nettype wire

// ----- hdl/ordered_byte_list_table_top.sv -----
// Top level of the ordered byte list table: sequencer plus a row of byte cells.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    mode, match_value, replacement
//   rsp_      out        rsp_valid/rsp_ready    matched_count, success, length_after
//
// Delete, count and replace walk the row of cells, one entry per cycle, over the L entries
// held at acceptance (at most 16); append, clear and unused modes skip the walk. After it
// the last scan step applies the mode and the finish state registers the result beat.
// Reset empties the list at once; the cells hold no reset value. A stalled result beat
// holds in the output register while the next request is accepted and worked on; that
// request then waits to finish until the beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module ordered_byte_list_table_top (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [2:0] req_mode,
   input  wire  [7:0] req_match_value,
   input  wire  [7:0] req_replacement,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [4:0] rsp_matched_count,
   output logic       rsp_success,
   output logic [4:0] rsp_length_after
);
   import olbt_pkg::*;

   // The list lives in cells 0 to length-1, head in cell 0. During a walk every cell
   // takes its right neighbor each cycle, so the head steps out of cell 0; a surviving
   // entry is written back just behind the entries not yet visited and those already kept,
   // which closes gaps while keeping the original order.
   chain_ctrl_type chain;
   logic [7:0]     cell_value [DEPTH];

   olbt_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_match_value   (req_match_value),
      .req_replacement   (req_replacement),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched_count (rsp_matched_count),
      .rsp_success       (rsp_success),
      .rsp_length_after  (rsp_length_after),
      .head_value        (cell_value[0]),
      .chain             (chain)
   );

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      cell_ctrl_type cctrl;
      logic [7:0]    right;

      assign cctrl.shift   = chain.shift;
      assign cctrl.load_en = chain.load && (chain.load_idx == IDX_W'(k));
      assign cctrl.data    = chain.data;

      // The last cell has no right neighbor and keeps its own byte when shifting.
      if (k == DEPTH - 1) begin : g_last
         assign right = cell_value[k];
      end else begin : g_mid
         assign right = cell_value[k + 1];
      end

      olbt_cell u_cell (
         .clock       (clock),
         .ctrl        (cctrl),
         .right_value (right),
         .value       (cell_value[k])
      );
   end

endmodule
`default_nettype wire

// ----- hdl/olbt_checker.sv -----
// Port-level assertions for the ordered byte list table, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module olbt_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [4:0] rsp_matched_count,
   input wire       rsp_success,
   input wire [4:0] rsp_length_after
);

   // A waiting result beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_matched_count) &&
                                     $stable(rsp_success) && $stable(rsp_length_after)))
      else $error("result beat changed while stalled");

   // Failed or ignored requests never report matches.
   a_fail_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |-> (rsp_matched_count == 5'd0))
      else $error("failed request reported matches");

   // Reset leaves no result beat behind.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // One request at a time: acceptance closes the request side for the next cycle.
   a_one_at_a_time: assert property (@(posedge clock)
      (!reset && req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

endmodule

bind ordered_byte_list_table_top olbt_checker u_olbt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_matched_count (rsp_matched_count),
   .rsp_success       (rsp_success),
   .rsp_length_after  (rsp_length_after)
);
`default_nettype wire
